FILE: sv/qrr_pkg.sv
// Shared types, codes and reset constants for the query request retry controller.
package qrr_pkg;

	typedef enum logic [2:0] {
		OP_POLL     = 3'd0,
		OP_TRIGGER  = 3'd1,
		OP_COMPLETE = 3'd2,
		OP_FRAME    = 3'd3,
		OP_INVAL    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT    = 2'd0,
		REG_MAX_RETRY  = 2'd1,
		REG_IDLE_RETRY = 2'd2
	} reg_idx_t;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned IN_TDATA_W = 40;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [15:0] TIMEOUT_RST    = 16'd1500;
	localparam logic [3:0]  MAX_RETRY_RST  = 4'd2;
	localparam logic [15:0] IDLE_RETRY_RST = 16'd2500;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [3:0]  max_retry;
		logic [15:0] idle_retry_ms;
	} cfg_t;

	typedef struct packed {
		logic        pending;
		logic        got_frame;
		logic        deferred;
		logic [3:0]  retry_count;
		logic [31:0] sent_time;
		logic [31:0] idle_time;
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] now_ms;
		logic        boot_done;
		logic        main_page_on;
	} item_t;

	typedef struct packed {
		logic send_request;
		logic had_pending;
		logic gave_up;
	} result_t;

endpackage

FILE: sv/query_request_retry_controller.sv
// Top level: input register, event evaluation, controller state and result register.
//
// Usage:
//   Events enter on the s_ group. s_tuser carries the operation code (poll,
//   trigger, complete, frame received, invalidate); s_tdata carries the
//   millisecond timestamp and the boot and main-page flags. Every event
//   yields exactly one result word on the m_ group, whose tdata holds the
//   send_request, had_pending and gave_up flags.
//   An accepted event is evaluated against the controller state in the input
//   register, and its result is then captured in the result register.
//   Throughput is one event per cycle while the result side is not stalled by
//   m_tready; the state update of each event is done as it leaves the input
//   register, so the next event sees it directly.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) writes timeout_ms,
//   max_retry and idle_retry_ms; write only while no event is in flight.
//   Reset clears all controller state and loads the default register values
//   (1500 ms timeout, 2 retries, 2500 ms idle interval).
//   When m_tready is low the result word holds; the input register still
//   fills, and s_tready drops only when both stages are occupied.
module query_request_retry_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] now_ms, [32] boot_done, [33] main_page_on, [39:34] zero
	input  logic [qrr_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [2:0] operation
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] send_request, [1] had_pending, [2] gave_up, [7:3] zero
	output logic [qrr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [qrr_pkg::CFG_W-1:0]         cfg_wdata
);
	import qrr_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.gave_up, res_s2.had_pending, res_s2.send_request};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms    <= TIMEOUT_RST;
			cfg_q.max_retry     <= MAX_RETRY_RST;
			cfg_q.idle_retry_ms <= IDLE_RETRY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT:    cfg_q.timeout_ms    <= cfg_wdata;
				REG_MAX_RETRY:  cfg_q.max_retry     <= cfg_wdata[3:0];
				REG_IDLE_RETRY: cfg_q.idle_retry_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation    <= s_tuser;
			item_s1.now_ms       <= s_tdata[31:0];
			item_s1.boot_done    <= s_tdata[32];
			item_s1.main_page_on <= s_tdata[33];
		end
	end

	qrr_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

`ifndef SYNTHESIS
	a_send_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_nxt.send_request |=> state_q.pending && !state_q.got_frame)
		else $error("issued request did not leave pending set");
	a_gave_up_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.gave_up && (res_s2.send_request || res_s2.had_pending)))
		else $error("gave_up combined with another result flag");
	a_complete_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.operation == OP_COMPLETE |=> !state_q.pending && state_q.got_frame)
		else $error("complete left request pending");
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("state changed without an event");
`endif

endmodule

FILE: sv/qrr_step.sv
// Event evaluation: next controller state and result word for one event.
module qrr_step (
	input  qrr_pkg::cfg_t    cfg,
	input  qrr_pkg::state_t  cur,
	input  qrr_pkg::item_t   item,
	output qrr_pkg::state_t  nxt,
	output qrr_pkg::result_t res
);
	import qrr_pkg::*;

	logic [31:0] sent_age;
	logic [31:0] idle_age;
	logic        timed_out;
	logic        idle_due;

	assign sent_age  = item.now_ms - cur.sent_time;
	assign idle_age  = item.now_ms - cur.idle_time;
	assign timed_out = cur.pending && (sent_age >= {16'd0, cfg.timeout_ms});
	assign idle_due  = idle_age >= {16'd0, cfg.idle_retry_ms};

	always_comb begin
		logic done;
		logic issue;
		done  = 1'b0;
		issue = 1'b0;
		nxt   = cur;
		res   = '0;
		case (item.operation)
			OP_POLL: begin
				if (timed_out) begin
					nxt.pending = 1'b0;
					if (!cur.got_frame) begin
						if (cur.retry_count < cfg.max_retry) begin
							nxt.retry_count = cur.retry_count + 4'd1;
							issue = 1'b1;
						end else begin
							nxt.idle_time = item.now_ms;
							res.gave_up = 1'b1;
						end
						done = 1'b1;
					end
				end
				if (!done && cur.deferred && !nxt.pending && item.boot_done) begin
					nxt.deferred = 1'b0;
					issue = 1'b1;
					done = 1'b1;
				end
				if (!done && !nxt.pending && !cur.got_frame && item.main_page_on &&
				    item.boot_done && idle_due) begin
					nxt.idle_time = item.now_ms;
					nxt.retry_count = '0;
					issue = 1'b1;
				end
			end
			OP_TRIGGER: begin
				nxt.retry_count = '0;
				if (!item.boot_done) begin
					nxt.deferred = 1'b1;
				end else begin
					nxt.deferred = 1'b0;
					issue = 1'b1;
				end
			end
			OP_COMPLETE: begin
				res.had_pending = cur.pending;
				nxt.pending = 1'b0;
				nxt.got_frame = 1'b1;
				nxt.retry_count = '0;
			end
			OP_FRAME: begin
				nxt.got_frame = 1'b1;
			end
			OP_INVAL: begin
				nxt.got_frame = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
		if (issue) begin
			nxt.pending = 1'b1;
			nxt.got_frame = 1'b0;
			nxt.sent_time = item.now_ms;
			res.send_request = 1'b1;
		end
	end

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the query request retry controller: directed and random events.
module tb_top;
	import qrr_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// [31:0] now_ms, [32] boot_done, [33] main_page_on, [39:34] zero
	logic [IN_TDATA_W-1:0]  s_tdata;
	// [2:0] operation
	logic [2:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// [0] send_request, [1] had_pending, [2] gave_up, [7:3] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [1:0]             cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	query_request_retry_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// controller copy
	logic [15:0] lim_timeout;
	logic [3:0]  lim_retries;
	logic [15:0] lim_idle;
	logic        ctl_pending;
	logic        ctl_got_frame;
	logic        ctl_deferred;
	logic [3:0]  ctl_retries;
	logic [31:0] ctl_sent_ms;
	logic [31:0] ctl_idle_ms;

	result_t     predicted_flags[$];
	logic [31:0] clock_ms;
	logic        tx_steady;
	logic        rx_steady;
	int          cycle_count = 0;
	int          n_errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_requests = 0;
	int          n_gave_up = 0;
	int          n_settings = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				predicted_flags.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic note_error(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		n_errors++;
	endtask

	function automatic void reset_controller();
		lim_timeout   = TIMEOUT_RST;
		lim_retries   = MAX_RETRY_RST;
		lim_idle      = IDLE_RETRY_RST;
		ctl_pending   = 1'b0;
		ctl_got_frame = 1'b0;
		ctl_deferred  = 1'b0;
		ctl_retries   = 4'd0;
		ctl_sent_ms   = 32'd0;
		ctl_idle_ms   = 32'd0;
	endfunction

	function automatic void issue_request(input logic [31:0] now, inout result_t r);
		ctl_pending   = 1'b1;
		ctl_got_frame = 1'b0;
		ctl_sent_ms   = now;
		r.send_request = 1'b1;
	endfunction

	function automatic result_t eval_event(input logic [2:0] op, input logic [31:0] now,
		input logic boot, input logic mainpg);
		result_t     r;
		logic        done;
		logic [31:0] elapsed;
		r = '0;
		done = 1'b0;
		case (op)
			OP_POLL: begin
				elapsed = now - ctl_sent_ms;
				if (ctl_pending && elapsed >= {16'd0, lim_timeout}) begin
					ctl_pending = 1'b0;
					if (!ctl_got_frame) begin
						if (ctl_retries < lim_retries) begin
							ctl_retries = ctl_retries + 4'd1;
							issue_request(now, r);
						end else begin
							ctl_idle_ms = now;
							r.gave_up = 1'b1;
						end
						done = 1'b1;
					end
				end
				if (!done && ctl_deferred && !ctl_pending && boot) begin
					ctl_deferred = 1'b0;
					issue_request(now, r);
					done = 1'b1;
				end
				elapsed = now - ctl_idle_ms;
				if (!done && !ctl_pending && !ctl_got_frame && mainpg && boot &&
					elapsed >= {16'd0, lim_idle}) begin
					ctl_idle_ms = now;
					ctl_retries = 4'd0;
					issue_request(now, r);
				end
			end
			OP_TRIGGER: begin
				ctl_retries = 4'd0;
				if (!boot) begin
					ctl_deferred = 1'b1;
				end else begin
					ctl_deferred = 1'b0;
					issue_request(now, r);
				end
			end
			OP_COMPLETE: begin
				r.had_pending = ctl_pending;
				ctl_pending   = 1'b0;
				ctl_got_frame = 1'b1;
				ctl_retries   = 4'd0;
			end
			OP_FRAME: ctl_got_frame = 1'b1;
			OP_INVAL: ctl_got_frame = 1'b0;
			default: ;
		endcase
		return r;
	endfunction

	// enters and leaves at a rising edge
	task automatic send_event(input logic [2:0] op, input logic [31:0] now, input logic boot,
		input logic mainpg);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, mainpg, boot, now};
		do @(posedge clk); while (!s_tready);
		predicted_flags.push_back(eval_event(op, now, boot, mainpg));
		n_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (predicted_flags.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT:    lim_timeout = value;
			REG_MAX_RETRY:  lim_retries = value[3:0];
			REG_IDLE_RETRY: lim_idle = value;
			default: ;
		endcase
	endtask

	task automatic send_random_event();
		logic [2:0] op;
		logic       boot;
		logic       mainpg;
		int         pick;
		int         span;
		int         scale;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			op = OP_POLL;
		else if (pick < 65)
			op = OP_TRIGGER;
		else if (pick < 75)
			op = OP_COMPLETE;
		else if (pick < 84)
			op = OP_FRAME;
		else if (pick < 93)
			op = OP_INVAL;
		else
			op = 3'($urandom_range(5, 7));
		span  = (lim_timeout > lim_idle) ? int'(lim_timeout) : int'(lim_idle);
		scale = span / 2 + 2;
		pick  = $urandom_range(0, 99);
		if (pick < 5)
			clock_ms = clock_ms;
		else if (pick < 75)
			clock_ms = clock_ms + $urandom_range(0, scale);
		else if (pick < 95)
			clock_ms = clock_ms + $urandom_range(scale, span * 2 + 4);
		else
			clock_ms = $urandom;
		boot   = ($urandom_range(0, 99) < 85);
		mainpg = ($urandom_range(0, 99) < 70);
		send_event(op, clock_ms, boot, mainpg);
	endtask

	// defer, timeouts with retries, give-up, frame-seen timeout, idle re-send
	task automatic test_basic_sequence();
		n_settings++;
		send_event(OP_POLL,     32'd0,    1'b1, 1'b1);
		send_event(OP_TRIGGER,  32'd100,  1'b0, 1'b0);
		send_event(OP_POLL,     32'd150,  1'b0, 1'b0);
		send_event(OP_POLL,     32'd200,  1'b1, 1'b0);
		send_event(OP_POLL,     32'd1700, 1'b1, 1'b0);
		send_event(OP_POLL,     32'd3200, 1'b1, 1'b0);
		send_event(OP_POLL,     32'd4700, 1'b1, 1'b0);
		send_event(OP_COMPLETE, 32'd4800, 1'b1, 1'b0);
		send_event(OP_TRIGGER,  32'd5000, 1'b1, 1'b0);
		send_event(OP_FRAME,    32'd5100, 1'b1, 1'b0);
		send_event(OP_POLL,     32'd6600, 1'b1, 1'b1);
		send_event(OP_INVAL,    32'd6700, 1'b1, 1'b0);
		send_event(OP_POLL,     32'd7300, 1'b1, 1'b1);
		send_event(OP_COMPLETE, 32'd7400, 1'b1, 1'b1);
		settle();
	endtask

	// zero intervals, masked and ignored writes, unknown codes, timestamp wrap
	task automatic test_special_cases();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_MAX_RETRY, 16'hFFF0);
		write_reg(REG_TIMEOUT, 16'd0);
		write_reg(REG_IDLE_RETRY, 16'd0);
		n_settings++;
		send_event(OP_TRIGGER,  32'hFFFF_FFFF, 1'b1, 1'b0);
		send_event(OP_POLL,     32'hFFFF_FFFF, 1'b1, 1'b0);
		send_event(OP_POLL,     32'd0,         1'b1, 1'b1);
		send_event(OP_COMPLETE, 32'd0,         1'b1, 1'b1);
		send_event(3'd5,        $urandom,      1'b1, 1'b1);
		send_event(3'd6,        $urandom,      1'b0, 1'b1);
		send_event(3'd7,        $urandom,      1'b1, 1'b0);
		send_event(OP_POLL,     32'd5,         1'b1, 1'b1);
		send_event(OP_INVAL,    32'd6,         1'b1, 1'b1);
		send_event(OP_POLL,     32'd7,         1'b1, 1'b1);
		settle();
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 9; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(REG_TIMEOUT, 16'd0);
					write_reg(REG_MAX_RETRY, 16'd0);
					write_reg(REG_IDLE_RETRY, 16'd0);
				end
				1: begin
					write_reg(REG_TIMEOUT, 16'hFFFF);
					write_reg(REG_MAX_RETRY, 16'hFFFF);
					write_reg(REG_IDLE_RETRY, 16'hFFFF);
				end
				2: begin
					write_reg(REG_TIMEOUT, 16'd1);
					write_reg(REG_MAX_RETRY, 16'd1);
					write_reg(REG_IDLE_RETRY, 16'd1);
				end
				default: begin
					write_reg(REG_TIMEOUT, ($urandom_range(0, 5) == 0) ?
						16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 300)));
					write_reg(REG_MAX_RETRY, 16'($urandom));
					write_reg(REG_IDLE_RETRY, ($urandom_range(0, 5) == 0) ?
						16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 600)));
					if ($urandom_range(0, 2) == 0)
						write_reg(REG_UNUSED, 16'($urandom));
				end
			endcase
			n_settings++;
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			clock_ms  = (ph == 3) ? 32'hFFFF_F000 : $urandom;
			repeat (184) send_random_event();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// result side: random stalls, each word checked against the oldest prediction
	initial begin
		result_t          want;
		logic [OUT_TDATA_W-1:0] got;
		int               stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			if (predicted_flags.size() == 0) begin
				note_error($sformatf("unexpected word 0x%02h", got));
			end else begin
				want = predicted_flags.pop_front();
				n_checked++;
				if (want.send_request)
					n_requests++;
				if (want.gave_up)
					n_gave_up++;
				if (got[0] !== want.send_request)
					note_error($sformatf("word %0d send_request: want %b got %b",
						n_checked, want.send_request, got[0]));
				if (got[1] !== want.had_pending)
					note_error($sformatf("word %0d had_pending: want %b got %b",
						n_checked, want.had_pending, got[1]));
				if (got[2] !== want.gave_up)
					note_error($sformatf("word %0d gave_up: want %b got %b",
						n_checked, want.gave_up, got[2]));
				if (got[OUT_TDATA_W-1:3] !== '0)
					note_error($sformatf("word %0d nonzero pad bits: 0x%02h", n_checked, got));
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		clock_ms  = 32'd0;
		reset_controller();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_sequence();
		test_special_cases();
		test_random_traffic();
		settle();
		repeat (4) @(posedge clk);

		$display("%0d events, %0d words checked over %0d register settings",
			n_sent, n_checked, n_settings);
		$display("%0d requests issued, %0d give-ups, %0d errors", n_requests, n_gave_up,
			n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
sv/qrr_pkg.sv
sv/qrr_step.sv
sv/query_request_retry_controller.sv
bench/tb_top.sv
